// ----- rtl/ipsl_pkg.sv -----
// Shared types and constants for the interior-point step length block.
// Holds the fixed-point format, controller states and the command/status structs.
// No dependencies.
package ipsl_pkg;

    localparam int FRAC_BITS = 16;
    localparam int VAL_W     = 32;
    localparam int TK_W      = 31;
    localparam int QUOT_W    = FRAC_BITS + 1;
    localparam int CNT_W     = $clog2(QUOT_W);
    localparam int PROD_W    = 2 * QUOT_W;

    localparam logic [QUOT_W-1:0] ONE_FX        = QUOT_W'(1) << FRAC_BITS;
    localparam logic [QUOT_W-1:0] SCALE_RESET   = QUOT_W'(64881);
    localparam logic [CNT_W-1:0]  DIV_LAST_STEP = CNT_W'(QUOT_W - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MIN,
        ST_MUL,
        ST_EMIT
    } ipsl_state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic update;
        logic mul;
        logic emit;
    } ipsl_cmd_t;

    typedef struct packed {
        logic close_mode;
        logic out_free;
    } ipsl_status_t;

endpackage

// ----- rtl/ipsl_div.sv -----
// One restoring divider lane: quotient of (num << FRAC_BITS) / den, one bit per cycle of step.
// Depends on ipsl_pkg. Flags the lane invalid when the quotient would not fit.
module ipsl_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         load,
    input  logic                         step,
    input  logic                         cand,
    input  logic [ipsl_pkg::VAL_W-1:0]   num_mag,
    input  logic [ipsl_pkg::VAL_W-1:0]   den_mag,
    output logic [ipsl_pkg::QUOT_W-1:0]  quot,
    output logic                         quot_valid
);
    import ipsl_pkg::*;

    logic [VAL_W-1:0]  rem_reg, rem_next;
    logic [VAL_W-1:0]  den_reg, den_next;
    logic [QUOT_W-1:0] quo_reg, quo_next;
    logic              bit_reg, bit_next;
    logic              valid_reg, valid_next;
    logic [VAL_W:0]    trial;
    logic              fits;

    // The quotient fits in QUOT_W bits exactly when num < 2 * den.
    assign fits = ({1'b0, num_mag} < {den_mag, 1'b0});
    assign trial = {rem_reg, bit_reg};

    always_comb begin
        rem_next   = rem_reg;
        den_next   = den_reg;
        quo_next   = quo_reg;
        bit_next   = bit_reg;
        valid_next = valid_reg;
        if (load) begin
            rem_next   = num_mag >> 1;
            den_next   = den_mag;
            quo_next   = '0;
            bit_next   = num_mag[0];
            valid_next = cand && (den_mag != '0) && fits;
        end else if (step) begin
            bit_next = 1'b0;
            if (trial >= {1'b0, den_reg}) begin
                rem_next = VAL_W'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[QUOT_W-2:0], 1'b1};
            end else begin
                rem_next = VAL_W'(trial);
                quo_next = {quo_reg[QUOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
        bit_reg <= bit_next;
    end

    assign quot       = quo_reg;
    assign quot_valid = valid_reg;

endmodule

// ----- rtl/ipsl_datapath.sv -----
// Datapath: operand capture, two divider lanes, running minimum, scaling and output register.
// Depends on ipsl_pkg and ipsl_div.
module ipsl_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ipsl_pkg::ipsl_cmd_t           cmd,
    output ipsl_pkg::ipsl_status_t        status,
    input  logic                          cfg_we,
    input  logic [ipsl_pkg::QUOT_W-1:0]   cfg_wdata,
    input  logic                          s_mode,
    input  logic signed [ipsl_pkg::VAL_W-1:0] s_slack_value,
    input  logic signed [ipsl_pkg::VAL_W-1:0] s_slack_step,
    input  logic signed [ipsl_pkg::VAL_W-1:0] s_dual_value,
    input  logic signed [ipsl_pkg::VAL_W-1:0] s_dual_step,
    input  logic [ipsl_pkg::TK_W-1:0]     s_tau_value,
    input  logic signed [ipsl_pkg::VAL_W-1:0] s_tau_step,
    input  logic [ipsl_pkg::TK_W-1:0]     s_kappa_value,
    input  logic signed [ipsl_pkg::VAL_W-1:0] s_kappa_step,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [ipsl_pkg::QUOT_W-1:0]   m_step_length
);
    import ipsl_pkg::*;

    logic [QUOT_W-1:0] scale_reg;
    logic [QUOT_W-1:0] min_reg, min_next;
    logic [PROD_W-1:0] prod_reg;
    logic [QUOT_W-1:0] out_reg;
    logic              out_valid_reg;
    logic              mode_reg;

    logic [VAL_W-1:0]  num0, den0, num1, den1;
    logic              cand0, cand1;
    logic [QUOT_W-1:0] q0, q1;
    logic              qv0, qv1;
    logic [PROD_W-FRAC_BITS-1:0] scaled;

    function automatic logic [VAL_W-1:0] mag(input logic [VAL_W-1:0] x);
        return x[VAL_W-1] ? VAL_W'(-x) : x;
    endfunction

    // Lane 0 takes the slack (or tau), lane 1 the dual (or kappa).
    always_comb begin
        if (s_mode) begin
            num0  = {1'b0, s_tau_value};
            den0  = mag(s_tau_step);
            cand0 = s_tau_step[VAL_W-1];
            num1  = {1'b0, s_kappa_value};
            den1  = mag(s_kappa_step);
            cand1 = s_kappa_step[VAL_W-1];
        end else begin
            num0  = mag(s_slack_value);
            den0  = mag(s_slack_step);
            cand0 = (s_slack_value != '0) && (s_slack_step != '0)
                    && (s_slack_value[VAL_W-1] != s_slack_step[VAL_W-1]);
            num1  = mag(s_dual_value);
            den1  = mag(s_dual_step);
            cand1 = (s_dual_value != '0) && (s_dual_step != '0)
                    && (s_dual_value[VAL_W-1] != s_dual_step[VAL_W-1]);
        end
    end

    ipsl_div u_div0 (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (cmd.load),
        .step       (cmd.step),
        .cand       (cand0),
        .num_mag    (num0),
        .den_mag    (den0),
        .quot       (q0),
        .quot_valid (qv0)
    );

    ipsl_div u_div1 (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (cmd.load),
        .step       (cmd.step),
        .cand       (cand1),
        .num_mag    (num1),
        .den_mag    (den1),
        .quot       (q1),
        .quot_valid (qv1)
    );

    always_comb begin
        min_next = min_reg;
        if (cmd.update) begin
            if (qv0 && (q0 < min_next)) begin
                min_next = q0;
            end
            if (qv1 && (q1 < min_next)) begin
                min_next = q1;
            end
        end else if (cmd.mul) begin
            min_next = ONE_FX;
        end
    end

    assign scaled = prod_reg[PROD_W-1:FRAC_BITS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg     <= SCALE_RESET;
            min_reg       <= ONE_FX;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                scale_reg <= cfg_wdata;
            end
            min_reg <= min_next;
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
        if (cmd.load) begin
            mode_reg <= s_mode;
        end
        if (cmd.mul) begin
            prod_reg <= PROD_W'(min_reg) * PROD_W'(scale_reg);
        end
        if (cmd.emit) begin
            out_reg <= (scaled > {{(PROD_W-FRAC_BITS-QUOT_W){1'b0}}, ONE_FX})
                       ? ONE_FX : QUOT_W'(scaled);
        end
    end

    assign status.close_mode = mode_reg;
    assign status.out_free   = !out_valid_reg || m_ready;
    assign m_valid           = out_valid_reg;
    assign m_step_length     = out_reg;

endmodule

// ----- rtl/ipsl_ctrl.sv -----
// Controller state machine: sequences load, division steps, minimum update, scaling and emit.
// Depends on ipsl_pkg.
module ipsl_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  ipsl_pkg::ipsl_status_t status,
    output ipsl_pkg::ipsl_cmd_t    cmd
);
    import ipsl_pkg::*;

    ipsl_state_t      state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST_STEP) begin
                    cnt_next   = '0;
                    state_next = ST_MIN;
                end
            end
            ST_MIN: begin
                cmd.update = 1'b1;
                state_next = status.close_mode ? ST_MUL : ST_IDLE;
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_cmd_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(cmd))
        else $error("more than one datapath command at once");

    a_accept_starts_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_DIV && cnt_reg == '0))
        else $error("accepted request did not start the divider");

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= DIV_LAST_STEP)
        else $error("division step counter out of range");

    a_emit_only_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> status.out_free)
        else $error("result emitted over an untaken result");

endmodule

// ----- rtl/interior_point_step_length.sv -----
// Top level of the interior-point step length block (fraction-to-boundary ratio test).
// Sequence: a mode 0 request is loaded, runs 17 divider steps and then the minimum update;
// a mode 1 request goes on to scale the minimum and raises m_valid once the output is free.
// Requests are taken one at a time, as s_ready is high only while idle; the bit-serial
// restoring dividers produce one quotient bit per cycle in each of two lanes.
// Reset (synchronous, active low) sets the running minimum to 1.0 and the factor to 64881.
module interior_point_step_length (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [ipsl_pkg::QUOT_W-1:0]       cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_mode,
    input  logic signed [ipsl_pkg::VAL_W-1:0] s_slack_value,
    input  logic signed [ipsl_pkg::VAL_W-1:0] s_slack_step,
    input  logic signed [ipsl_pkg::VAL_W-1:0] s_dual_value,
    input  logic signed [ipsl_pkg::VAL_W-1:0] s_dual_step,
    input  logic [ipsl_pkg::TK_W-1:0]         s_tau_value,
    input  logic signed [ipsl_pkg::VAL_W-1:0] s_tau_step,
    input  logic [ipsl_pkg::TK_W-1:0]         s_kappa_value,
    input  logic signed [ipsl_pkg::VAL_W-1:0] s_kappa_step,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [ipsl_pkg::QUOT_W-1:0]       m_step_length
);
    import ipsl_pkg::*;

    // The controller only issues commands; all data arithmetic and storage live in the
    // datapath. Each request loads both divider lanes, which then run in lockstep.
    // Mode 0 requests feed the slack and dual pairs, mode 1 requests feed tau and kappa.
    ipsl_cmd_t    cmd;
    ipsl_status_t status;

    ipsl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // The output register lets a new request be accepted while a result waits.
    ipsl_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_mode        (s_mode),
        .s_slack_value (s_slack_value),
        .s_slack_step  (s_slack_step),
        .s_dual_value  (s_dual_value),
        .s_dual_step   (s_dual_step),
        .s_tau_value   (s_tau_value),
        .s_tau_step    (s_tau_step),
        .s_kappa_value (s_kappa_value),
        .s_kappa_step  (s_kappa_step),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_step_length (m_step_length)
    );

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for interior_point_step_length, the fraction-to-boundary step block.
// Drives element and closing requests and predicts each scaled step length in the bench.
// Depends on rtl/ipsl_pkg.sv and rtl/interior_point_step_length.sv.
module tb_top;

    import ipsl_pkg::*;

    // Request modes as the block decodes them.
    localparam logic MODE_ELEMENT = 1'b0;
    localparam logic MODE_CLOSING = 1'b1;

    // Cycles to let pass after the last result. A trailing element request may still be
    // in its divider, and it must finish before the block is idle.
    localparam int SETTLE_CYCLES = 30;

    // Only the first mismatches are printed, so a broken build does not flood the log.
    localparam int PRINT_LIMIT = 100;

    typedef struct packed {
        logic              mode;
        logic [VAL_W-1:0]  slack_value;
        logic [VAL_W-1:0]  slack_step;
        logic [VAL_W-1:0]  dual_value;
        logic [VAL_W-1:0]  dual_step;
        logic [TK_W-1:0]   tau_value;
        logic [VAL_W-1:0]  tau_step;
        logic [TK_W-1:0]   kappa_value;
        logic [VAL_W-1:0]  kappa_step;
    } step_request_t;

    logic              aclk;
    logic              aresetn;
    logic              cfg_we;
    logic [QUOT_W-1:0] cfg_wdata;
    logic              s_valid;
    logic              s_ready;
    logic              s_mode;
    logic [VAL_W-1:0]  s_slack_value;
    logic [VAL_W-1:0]  s_slack_step;
    logic [VAL_W-1:0]  s_dual_value;
    logic [VAL_W-1:0]  s_dual_step;
    logic [TK_W-1:0]   s_tau_value;
    logic [VAL_W-1:0]  s_tau_step;
    logic [TK_W-1:0]   s_kappa_value;
    logic [VAL_W-1:0]  s_kappa_step;
    logic              m_valid;
    logic              m_ready;
    logic [QUOT_W-1:0] m_step_length;

    // The bench's own copy of the block state: the running ratio minimum and the
    // backtrack factor. Step lengths still owed by the block wait in arrival order.
    logic [QUOT_W-1:0] ratio_min;
    logic [QUOT_W-1:0] backtrack_factor;
    logic [QUOT_W-1:0] owed_lengths[$];
    logic [QUOT_W-1:0] oldest_length;

    int error_count;
    int send_idle_pct;
    int recv_idle_pct;

    interior_point_step_length dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_slack_value (s_slack_value),
        .s_slack_step  (s_slack_step),
        .s_dual_value  (s_dual_value),
        .s_dual_step   (s_dual_step),
        .s_tau_value   (s_tau_value),
        .s_tau_step    (s_tau_step),
        .s_kappa_value (s_kappa_value),
        .s_kappa_step  (s_kappa_step),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_step_length (m_step_length)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Hard stop in case the block hangs or a result never shows up.
    initial begin
        #8000000;
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // Step length predictor
    // ------------------------------------------------------------------

    function automatic logic [VAL_W-1:0] magnitude(input logic [VAL_W-1:0] x);
        // The most negative value maps to 2^31, which still fits as unsigned.
        return x[VAL_W-1] ? -x : x;
    endfunction

    // Lower the running minimum to (num << FRAC_BITS) / den, truncated, if that is
    // smaller. A zero denominator never offers a candidate.
    function automatic void offer_ratio(input logic [VAL_W-1:0] num,
                                        input logic [VAL_W-1:0] den);
        logic [63:0] quotient;
        if (den != '0) begin
            quotient = ({32'd0, num} << FRAC_BITS) / {32'd0, den};
            if (quotient < 64'(ratio_min))
                ratio_min = quotient[QUOT_W-1:0];
        end
    endfunction

    // A slack or dual limits the step only when value and step are both nonzero and
    // of opposite sign, so that the exact ratio -value/step is positive.
    function automatic void offer_element(input logic [VAL_W-1:0] value,
                                          input logic [VAL_W-1:0] step);
        if (value != '0 && step != '0 && value[VAL_W-1] != step[VAL_W-1])
            offer_ratio(magnitude(value), magnitude(step));
    endfunction

    // Tau or kappa limits the step whenever its step is negative, even at value zero.
    function automatic void offer_scalar(input logic [TK_W-1:0] value,
                                         input logic [VAL_W-1:0] step);
        if (step[VAL_W-1])
            offer_ratio({1'b0, value}, magnitude(step));
    endfunction

    // Advance the predicted state by one accepted request. A closing request owes one
    // step length: the minimum scaled by the factor, clamped at 1.0, after which the
    // minimum starts again from 1.0.
    function automatic void predict_step_length(input step_request_t req);
        logic [2*QUOT_W-1:0] product;
        logic [2*QUOT_W-1:0] scaled;
        if (req.mode == MODE_ELEMENT) begin
            offer_element(req.slack_value, req.slack_step);
            offer_element(req.dual_value, req.dual_step);
        end else begin
            offer_scalar(req.tau_value, req.tau_step);
            offer_scalar(req.kappa_value, req.kappa_step);
            product = PROD_W'(ratio_min) * PROD_W'(backtrack_factor);
            scaled = product >> FRAC_BITS;
            if (scaled > PROD_W'(ONE_FX))
                scaled = PROD_W'(ONE_FX);
            owed_lengths.push_back(scaled[QUOT_W-1:0]);
            ratio_min = ONE_FX;
        end
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        if (error_count < PRINT_LIMIT)
            $display("ERROR: %s", msg);
        error_count++;
    endtask

    // Every accepted result is matched against the oldest owed step length. Sampling at
    // the clock edge sees the values from before the edge, so no race with the block.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (owed_lengths.size() == 0) begin
                report_mismatch($sformatf("step length %0d arrived with none owed",
                                          m_step_length));
            end else begin
                oldest_length = owed_lengths.pop_front();
                if (m_step_length !== oldest_length)
                    report_mismatch($sformatf("step_length got %0d, want %0d",
                                              m_step_length, oldest_length));
            end
        end
    end

    // The receiver holds off at random in recv_idle_pct cycles of a hundred.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------
    // Request driving
    // ------------------------------------------------------------------

    // Send one request. Idle cycles come before valid rises; once valid is high it is
    // held with the payload until the block takes the request. Valid is left high on
    // return, so a back-to-back request keeps it high without a glitch.
    task automatic send_request(input step_request_t req);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_mode        <= req.mode;
        s_slack_value <= req.slack_value;
        s_slack_step  <= req.slack_step;
        s_dual_value  <= req.dual_value;
        s_dual_step   <= req.dual_step;
        s_tau_value   <= req.tau_value;
        s_tau_step    <= req.tau_step;
        s_kappa_value <= req.kappa_value;
        s_kappa_step  <= req.kappa_step;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        predict_step_length(req);
    endtask

    // Stop sending, wait for every owed result, then let a trailing element request
    // finish in the divider. After this the block is idle.
    task automatic drain_block;
        s_valid <= 1'b0;
        while (owed_lengths.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write the backtrack factor. Only called with the block idle.
    task automatic write_backtrack_factor(input logic [QUOT_W-1:0] factor);
        drain_block();
        cfg_we    <= 1'b1;
        cfg_wdata <= factor;
        @(posedge aclk);
        cfg_we <= 1'b0;
        backtrack_factor = factor;
    endtask

    // Element request: the tau and kappa fields are ignored, so they carry noise.
    function automatic step_request_t element_request(input logic [VAL_W-1:0] sv,
                                                      input logic [VAL_W-1:0] ss,
                                                      input logic [VAL_W-1:0] dv,
                                                      input logic [VAL_W-1:0] ds);
        step_request_t req;
        req.mode        = MODE_ELEMENT;
        req.slack_value = sv;
        req.slack_step  = ss;
        req.dual_value  = dv;
        req.dual_step   = ds;
        req.tau_value   = TK_W'($urandom);
        req.tau_step    = $urandom;
        req.kappa_value = TK_W'($urandom);
        req.kappa_step  = $urandom;
        return req;
    endfunction

    // Closing request: the slack and dual fields are ignored, so they carry noise.
    function automatic step_request_t closing_request(input logic [TK_W-1:0]  tv,
                                                      input logic [VAL_W-1:0] ts,
                                                      input logic [TK_W-1:0]  kv,
                                                      input logic [VAL_W-1:0] ks);
        step_request_t req;
        req.mode        = MODE_CLOSING;
        req.slack_value = $urandom;
        req.slack_step  = $urandom;
        req.dual_value  = $urandom;
        req.dual_step   = $urandom;
        req.tau_value   = tv;
        req.tau_step    = ts;
        req.kappa_value = kv;
        req.kappa_step  = ks;
        return req;
    endfunction

    // Random fixed-point value. Most draws have a random magnitude and sign so that
    // ratios below 1.0 are common; the rest are full-range, zero or the extremes.
    function automatic logic [VAL_W-1:0] random_fixed;
        logic [VAL_W-1:0] r;
        case ($urandom_range(0, 7))
            0: r = $urandom;
            1: r = '0;
            2: begin
                case ($urandom_range(0, 3))
                    0: r = 32'h8000_0000;
                    1: r = 32'h7FFF_FFFF;
                    2: r = 32'h0000_0001;
                    default: r = 32'hFFFF_FFFF;
                endcase
            end
            default: begin
                r = $urandom >> $urandom_range(0, 31);
                if ($urandom_range(0, 1) == 1)
                    r = -r;
            end
        endcase
        return r;
    endfunction

    function automatic logic [TK_W-1:0] random_scalar;
        logic [VAL_W-1:0] r;
        r = magnitude(random_fixed());
        return r[TK_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Out of reset the factor is 64881 and the minimum 1.0. Closing requests whose
    // steps are zero or positive offer nothing, so they return the bare factor.
    task automatic test_reset_factor;
        send_request(closing_request(31'h7FFF_FFFF, 32'h0000_0005, 31'h0, 32'h0));
        send_request(closing_request(31'h0, 32'h0, 31'h1234, 32'h7FFF_FFFF));
    endtask

    // Element pairs: huge ratios, a ratio that truncates to zero, zero values, zero
    // steps, like signs, a ratio of exactly 1.0 and plain fractions.
    task automatic test_element_ratios;
        send_request(element_request(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFB));
        send_request(element_request(32'h0000_0001, 32'h8000_0000, 32'h5, 32'h5));
        send_request(closing_request(31'h0, 32'h0, 31'h0, 32'h0));
        send_request(element_request(32'hFFFF_FFFD, 32'h6, 32'h8000_0000, 32'h7FFF_FFFF));
        send_request(element_request(32'hA, 32'h0, 32'h8, 32'hFFFF_FFF8));
        send_request(closing_request(31'h0, 32'h0, 31'h0, 32'h0));
        send_request(element_request(32'h0001_0000, 32'hFFFE_0000,
                                     32'hFFFF_0000, 32'h8000_0000));
        send_request(closing_request(31'h5, 32'h1, 31'h7, 32'h0));
    endtask

    // Closing scalars: a negative step at value zero, the extreme magnitudes, and the
    // smaller of two tau and kappa ratios winning.
    task automatic test_closing_ratios;
        send_request(closing_request(31'h0, 32'hFFFF_FFFF, 31'h3, 32'h4));
        send_request(closing_request(31'h7FFF_FFFF, 32'h8000_0000, 31'h3, 32'h4));
        send_request(closing_request(31'h1, 32'h8000_0000, 31'h7FFF_FFFF, 32'hFFFF_FFFF));
        send_request(closing_request(31'h8000, 32'hFFFF_0000, 31'h4000, 32'hFFFF_0000));
    endtask

    // Factor extremes: zero, exactly 1.0, the top of the register (where the result
    // clamps at 1.0) and the smallest nonzero factor.
    task automatic test_factor_extremes;
        write_backtrack_factor(17'd0);
        send_request(element_request(32'h0000_8000, 32'hFFFF_0000, 32'h0, 32'h0));
        send_request(closing_request(31'h0, 32'h0, 31'h0, 32'h0));
        write_backtrack_factor(ONE_FX);
        send_request(closing_request(31'h0, 32'h0, 31'h0, 32'h0));
        send_request(element_request(32'hFFFF_FFFD, 32'h6, 32'h0, 32'h0));
        send_request(closing_request(31'h0, 32'h0, 31'h0, 32'h0));
        write_backtrack_factor(17'h1_FFFF);
        send_request(closing_request(31'h0, 32'h0, 31'h0, 32'h0));
        send_request(closing_request(31'h3, 32'hFFFF_FFFC, 31'h0, 32'h0));
        write_backtrack_factor(17'd1);
        send_request(closing_request(31'h0, 32'h0, 31'h0, 32'h0));
    endtask

    // Random traffic: mostly runs of element requests closed by a closing request,
    // with the odd back-to-back closing and long runs. Half way through the sender
    // stops until every result is back and the factor is rewritten.
    task automatic test_random_traffic(input int n_requests, input int send_pct,
                                       input int recv_pct);
        int sent;
        int run_len;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        write_backtrack_factor(QUOT_W'($urandom_range(0, ONE_FX)));
        sent = 0;
        while (sent < n_requests) begin
            case ($urandom_range(0, 9))
                0: run_len = 0;
                1: run_len = $urandom_range(9, 24);
                default: run_len = $urandom_range(1, 6);
            endcase
            repeat (run_len) begin
                send_request(element_request(random_fixed(), random_fixed(),
                                             random_fixed(), random_fixed()));
            end
            send_request(closing_request(random_scalar(), random_fixed(),
                                         random_scalar(), random_fixed()));
            if (sent < n_requests / 2 && sent + run_len + 1 >= n_requests / 2)
                write_backtrack_factor(QUOT_W'($urandom_range(0, ONE_FX)));
            sent += run_len + 1;
        end
    endtask

    initial begin
        aresetn       <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_wdata     <= '0;
        s_valid       <= 1'b0;
        s_mode        <= MODE_ELEMENT;
        s_slack_value <= '0;
        s_slack_step  <= '0;
        s_dual_value  <= '0;
        s_dual_step   <= '0;
        s_tau_value   <= '0;
        s_tau_step    <= '0;
        s_kappa_value <= '0;
        s_kappa_step  <= '0;
        m_ready       <= 1'b0;
        error_count      = 0;
        send_idle_pct    = 0;
        recv_idle_pct    = 0;
        ratio_min        = ONE_FX;
        backtrack_factor = SCALE_RESET;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_factor();
        test_element_ratios();
        test_closing_ratios();
        test_factor_extremes();
        test_random_traffic(630, 12, 81);
        test_random_traffic(630, 81, 12);
        test_random_traffic(640, 0, 0);

        drain_block();
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
